/* rtl/ray_triangle_nearest_hit_unit_assert.svh */
// Assertion macros for the ray/triangle nearest-hit unit.
// Used by the top level only; relies on clk and rst_n in the enclosing scope.
`ifndef RAY_TRIANGLE_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_NEAREST_HIT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RTNH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtnh assertion failed");
`define RTNH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtnh assertion failed");
`else
`define RTNH_ASSERT_NOW(label, ante, cons)
`define RTNH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/rtnh_pkg.sv */
// Shared types, constants and helper functions of the ray/triangle nearest-hit unit.
// Depends on nothing; the front, queue, back and top-level files use it by scoped names.
package rtnh_pkg;

  localparam int COORD_W       = 32;
  localparam int DIFF_W        = 33;
  localparam int FACE_ID_WIDTH = 16;
  localparam int THR_W         = 40;
  localparam int DIST_W        = 31;
  localparam int PQ_W          = 68;
  localparam int ACC_W         = 104;
  localparam int DIV_W         = ACC_W + DIST_W;
  localparam int POS_W         = 48;
  localparam int MUL_BITS      = 33;
  localparam int BIT_W         = 6;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_LVL_W       = $clog2(Q_DEPTH + 1);
  localparam int UOP_W         = 5;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 40;

  localparam logic [UOP_W-1:0] UOP_GEO_END = 5'd23;
  localparam logic [UOP_W-1:0] UOP_POS0    = 5'd24;
  localparam logic [UOP_W-1:0] UOP_END     = 5'd26;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THR      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 4'd7;

  localparam logic signed [COORD_W-1:0] DIR_Z_RESET = 32'sd65536;
  localparam logic [THR_W-1:0]          THR_RESET   = 40'd281474977;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PQ_W-1:0]    pq_t;

  typedef struct packed {
    coord_t [2:0]       origin;
    coord_t [2:0]       dir;
    logic [THR_W-1:0]   thr;
    logic [DIST_W-1:0]  min_dist;
  } rtnh_cfg_t;

  typedef struct packed {
    diff_t [2:0]               e1;
    diff_t [2:0]               e2;
    diff_t [2:0]               tv;
    logic [FACE_ID_WIDTH-1:0]  face;
    logic                      last;
  } rtnh_tri_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_LVL_W-1:0] level;
  } rtnh_qstat_t;

  typedef enum logic [4:0] {
    SRC_DIR_X, SRC_DIR_Y, SRC_DIR_Z,
    SRC_E1_X, SRC_E1_Y, SRC_E1_Z,
    SRC_E2_X, SRC_E2_Y, SRC_E2_Z,
    SRC_TV_X, SRC_TV_Y, SRC_TV_Z,
    SRC_P_X, SRC_P_Y, SRC_P_Z,
    SRC_Q_X, SRC_Q_Y, SRC_Q_Z,
    SRC_DIST
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_P_X, DST_P_Y, DST_P_Z,
    DST_Q_X, DST_Q_Y, DST_Q_Z,
    DST_DET, DST_UN, DST_VN, DST_TN,
    DST_POS_X, DST_POS_Y, DST_POS_Z
  } dst_t;

  typedef struct packed {
    src_t xs;
    src_t ys;
    logic sub;
    logic first;
    dst_t dst;
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MAC, ST_NORM, ST_TEST, ST_SAT, ST_DIV, ST_QUAL, ST_DONE
  } back_state_t;

  function automatic logic signed [ACC_W-1:0] sx_coord(input logic signed [COORD_W-1:0] v);
    return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sx_diff(input logic signed [DIFF_W-1:0] v);
    return {{(ACC_W-DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sx_pq(input logic signed [PQ_W-1:0] v);
    return {{(ACC_W-PQ_W){v[PQ_W-1]}}, v};
  endfunction

  function automatic uop_t uop_mk(input src_t xs, input src_t ys, input logic sub,
                                  input logic first, input dst_t dst);
    uop_t u;
    u.xs    = xs;
    u.ys    = ys;
    u.sub   = sub;
    u.first = first;
    u.dst   = dst;
    return u;
  endfunction

  // Product terms: the two cross products, the four dot products, then the
  // three position offsets. A term with a destination closes its sum.
  function automatic uop_t rtnh_uop(input logic [UOP_W-1:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:  u = uop_mk(SRC_DIR_Y, SRC_E2_Z, 1'b0, 1'b1, DST_NONE);
      5'd1:  u = uop_mk(SRC_DIR_Z, SRC_E2_Y, 1'b1, 1'b0, DST_P_X);
      5'd2:  u = uop_mk(SRC_DIR_Z, SRC_E2_X, 1'b0, 1'b1, DST_NONE);
      5'd3:  u = uop_mk(SRC_DIR_X, SRC_E2_Z, 1'b1, 1'b0, DST_P_Y);
      5'd4:  u = uop_mk(SRC_DIR_X, SRC_E2_Y, 1'b0, 1'b1, DST_NONE);
      5'd5:  u = uop_mk(SRC_DIR_Y, SRC_E2_X, 1'b1, 1'b0, DST_P_Z);
      5'd6:  u = uop_mk(SRC_TV_Y, SRC_E1_Z, 1'b0, 1'b1, DST_NONE);
      5'd7:  u = uop_mk(SRC_TV_Z, SRC_E1_Y, 1'b1, 1'b0, DST_Q_X);
      5'd8:  u = uop_mk(SRC_TV_Z, SRC_E1_X, 1'b0, 1'b1, DST_NONE);
      5'd9:  u = uop_mk(SRC_TV_X, SRC_E1_Z, 1'b1, 1'b0, DST_Q_Y);
      5'd10: u = uop_mk(SRC_TV_X, SRC_E1_Y, 1'b0, 1'b1, DST_NONE);
      5'd11: u = uop_mk(SRC_TV_Y, SRC_E1_X, 1'b1, 1'b0, DST_Q_Z);
      5'd12: u = uop_mk(SRC_P_X, SRC_E1_X, 1'b0, 1'b1, DST_NONE);
      5'd13: u = uop_mk(SRC_P_Y, SRC_E1_Y, 1'b0, 1'b0, DST_NONE);
      5'd14: u = uop_mk(SRC_P_Z, SRC_E1_Z, 1'b0, 1'b0, DST_DET);
      5'd15: u = uop_mk(SRC_P_X, SRC_TV_X, 1'b0, 1'b1, DST_NONE);
      5'd16: u = uop_mk(SRC_P_Y, SRC_TV_Y, 1'b0, 1'b0, DST_NONE);
      5'd17: u = uop_mk(SRC_P_Z, SRC_TV_Z, 1'b0, 1'b0, DST_UN);
      5'd18: u = uop_mk(SRC_Q_X, SRC_DIR_X, 1'b0, 1'b1, DST_NONE);
      5'd19: u = uop_mk(SRC_Q_Y, SRC_DIR_Y, 1'b0, 1'b0, DST_NONE);
      5'd20: u = uop_mk(SRC_Q_Z, SRC_DIR_Z, 1'b0, 1'b0, DST_VN);
      5'd21: u = uop_mk(SRC_Q_X, SRC_E2_X, 1'b0, 1'b1, DST_NONE);
      5'd22: u = uop_mk(SRC_Q_Y, SRC_E2_Y, 1'b0, 1'b0, DST_NONE);
      5'd23: u = uop_mk(SRC_Q_Z, SRC_E2_Z, 1'b0, 1'b0, DST_TN);
      5'd24: u = uop_mk(SRC_DIR_X, SRC_DIST, 1'b0, 1'b1, DST_POS_X);
      5'd25: u = uop_mk(SRC_DIR_Y, SRC_DIST, 1'b0, 1'b1, DST_POS_Y);
      5'd26: u = uop_mk(SRC_DIR_Z, SRC_DIST, 1'b0, 1'b1, DST_POS_Z);
      default: u = uop_mk(SRC_DIR_X, SRC_DIR_X, 1'b0, 1'b1, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

/* rtl/rtnh_front.sv */
// Front part of the ray/triangle nearest-hit unit: takes triangles and forms
// the edge and origin vectors. Depends on rtnh_pkg.
module rtnh_front (
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_a_x,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_a_y,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_a_z,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_b_x,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_b_y,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_b_z,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_c_x,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_c_y,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_c_z,
  input  logic [rtnh_pkg::FACE_ID_WIDTH-1:0]      in_face_id,
  input  logic                                    in_last_face,
  input  rtnh_pkg::rtnh_cfg_t                     cfg,
  input  rtnh_pkg::rtnh_qstat_t                   q_stat,
  output logic                                    q_push,
  output rtnh_pkg::rtnh_tri_t                     q_data
);

  function automatic rtnh_pkg::diff_t sub33(input rtnh_pkg::coord_t x, input rtnh_pkg::coord_t y);
    return rtnh_pkg::diff_t'({x[rtnh_pkg::COORD_W-1], x}) -
           rtnh_pkg::diff_t'({y[rtnh_pkg::COORD_W-1], y});
  endfunction

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_data.e1[0] = sub33(in_b_x, in_a_x);
    q_data.e1[1] = sub33(in_b_y, in_a_y);
    q_data.e1[2] = sub33(in_b_z, in_a_z);
    q_data.e2[0] = sub33(in_c_x, in_a_x);
    q_data.e2[1] = sub33(in_c_y, in_a_y);
    q_data.e2[2] = sub33(in_c_z, in_a_z);
    q_data.tv[0] = sub33(cfg.origin[0], in_a_x);
    q_data.tv[1] = sub33(cfg.origin[1], in_a_y);
    q_data.tv[2] = sub33(cfg.origin[2], in_a_z);
    q_data.face  = in_face_id;
    q_data.last  = in_last_face;
  end

endmodule

/* rtl/rtnh_fifo.sv */
// Short triangle queue between the front and back parts of the nearest-hit unit.
// Depends on rtnh_pkg.
module rtnh_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rtnh_pkg::rtnh_tri_t    wr_data,
  input  logic                   pop,
  output rtnh_pkg::rtnh_tri_t    head,
  output rtnh_pkg::rtnh_qstat_t  stat
);

  rtnh_pkg::rtnh_tri_t               mem_r [rtnh_pkg::Q_DEPTH];
  logic [rtnh_pkg::Q_PTR_W-1:0]      wr_ptr_r;
  logic [rtnh_pkg::Q_PTR_W-1:0]      rd_ptr_r;
  logic [rtnh_pkg::Q_LVL_W-1:0]      level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.full  = (level_r == rtnh_pkg::Q_LVL_W'(rtnh_pkg::Q_DEPTH));
  assign stat.empty = (level_r == '0);

endmodule

/* rtl/rtnh_back.sv */
// Back part of the nearest-hit unit: bit-serial multiply-accumulate sequencer,
// hit tests, restoring divider, nearest-hit tracking and result register. Uses rtnh_pkg.
module rtnh_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rtnh_pkg::rtnh_cfg_t                   cfg,
  input  rtnh_pkg::rtnh_tri_t                   head,
  input  rtnh_pkg::rtnh_qstat_t                 q_stat,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit_found,
  output logic [rtnh_pkg::FACE_ID_WIDTH-1:0]    out_hit_face,
  output logic [rtnh_pkg::DIST_W-1:0]           out_hit_distance,
  output logic signed [rtnh_pkg::COORD_W-1:0]   out_hit_x,
  output logic signed [rtnh_pkg::COORD_W-1:0]   out_hit_y,
  output logic signed [rtnh_pkg::COORD_W-1:0]   out_hit_z
);

  localparam int AW = rtnh_pkg::ACC_W;

  rtnh_pkg::back_state_t state_r, state_nxt;

  logic signed [AW-1:0]                mx_r, acc_r, acc_nxt, contrib;
  logic [rtnh_pkg::MUL_BITS-1:0]       my_r;
  logic [rtnh_pkg::BIT_W-1:0]          bit_r;
  logic [rtnh_pkg::UOP_W-1:0]          uop_r;
  rtnh_pkg::pq_t [2:0]                 p_r, q_r;
  logic signed [AW-1:0]                det_r, un_r, vn_r, tn_r;
  logic [rtnh_pkg::DIV_W-1:0]          rem_r, step_r;
  logic [rtnh_pkg::DIST_W-1:0]         quo_r;
  logic                                sat_r;
  logic                                best_valid_r;
  logic [rtnh_pkg::FACE_ID_WIDTH-1:0]  best_face_r;
  logic [rtnh_pkg::DIST_W-1:0]         best_dist_r;
  rtnh_pkg::coord_t [2:0]              best_pos_r;
  logic                                out_valid_r;

  rtnh_pkg::uop_t uop;
  logic signed [AW-1:0] x_op, y_op;
  logic mac_end, geom_ok, sat_hit, div_end, take, out_free, finish;
  logic do_load, do_mac, do_norm, do_test, do_sat, do_div, do_qual, do_done, emit;
  logic signed [AW:0] uv_sum;
  logic signed [rtnh_pkg::POS_W-1:0] pos_sum;
  rtnh_pkg::coord_t pos_sat;
  logic [1:0] pos_k;

  function automatic logic signed [AW-1:0] opnd(
    input rtnh_pkg::src_t s, input rtnh_pkg::rtnh_tri_t t, input rtnh_pkg::rtnh_cfg_t c,
    input rtnh_pkg::pq_t [2:0] p, input rtnh_pkg::pq_t [2:0] q,
    input logic [rtnh_pkg::DIST_W-1:0] d);
    logic signed [AW-1:0] v;
    unique case (s)
      rtnh_pkg::SRC_DIR_X: v = rtnh_pkg::sx_coord(c.dir[0]);
      rtnh_pkg::SRC_DIR_Y: v = rtnh_pkg::sx_coord(c.dir[1]);
      rtnh_pkg::SRC_DIR_Z: v = rtnh_pkg::sx_coord(c.dir[2]);
      rtnh_pkg::SRC_E1_X:  v = rtnh_pkg::sx_diff(t.e1[0]);
      rtnh_pkg::SRC_E1_Y:  v = rtnh_pkg::sx_diff(t.e1[1]);
      rtnh_pkg::SRC_E1_Z:  v = rtnh_pkg::sx_diff(t.e1[2]);
      rtnh_pkg::SRC_E2_X:  v = rtnh_pkg::sx_diff(t.e2[0]);
      rtnh_pkg::SRC_E2_Y:  v = rtnh_pkg::sx_diff(t.e2[1]);
      rtnh_pkg::SRC_E2_Z:  v = rtnh_pkg::sx_diff(t.e2[2]);
      rtnh_pkg::SRC_TV_X:  v = rtnh_pkg::sx_diff(t.tv[0]);
      rtnh_pkg::SRC_TV_Y:  v = rtnh_pkg::sx_diff(t.tv[1]);
      rtnh_pkg::SRC_TV_Z:  v = rtnh_pkg::sx_diff(t.tv[2]);
      rtnh_pkg::SRC_P_X:   v = rtnh_pkg::sx_pq(p[0]);
      rtnh_pkg::SRC_P_Y:   v = rtnh_pkg::sx_pq(p[1]);
      rtnh_pkg::SRC_P_Z:   v = rtnh_pkg::sx_pq(p[2]);
      rtnh_pkg::SRC_Q_X:   v = rtnh_pkg::sx_pq(q[0]);
      rtnh_pkg::SRC_Q_Y:   v = rtnh_pkg::sx_pq(q[1]);
      rtnh_pkg::SRC_Q_Z:   v = rtnh_pkg::sx_pq(q[2]);
      rtnh_pkg::SRC_DIST:  v = {{(AW-rtnh_pkg::DIST_W){1'b0}}, d};
      default:             v = '0;
    endcase
    return v;
  endfunction

  // Datapath conditions
  always_comb begin
    uop     = rtnh_pkg::rtnh_uop(uop_r);
    x_op    = opnd(uop.xs, head, cfg, p_r, q_r, quo_r);
    y_op    = opnd(uop.ys, head, cfg, p_r, q_r, quo_r);
    contrib = my_r[0] ? mx_r : '0;
    // The top bit of the multiplier carries negative weight.
    if ((bit_r == rtnh_pkg::BIT_W'(rtnh_pkg::MUL_BITS - 1)) ^ uop.sub) begin
      acc_nxt = acc_r - contrib;
    end else begin
      acc_nxt = acc_r + contrib;
    end
    mac_end = (bit_r == rtnh_pkg::BIT_W'(rtnh_pkg::MUL_BITS - 1));
    div_end = (bit_r == rtnh_pkg::BIT_W'(rtnh_pkg::DIST_W - 1));
    uv_sum  = {un_r[AW-1], un_r} + {vn_r[AW-1], vn_r};
    geom_ok = (det_r != '0)
           && (det_r >= $signed({{(AW-rtnh_pkg::THR_W){1'b0}}, cfg.thr}))
           && !un_r[AW-1] && (un_r <= det_r)
           && !vn_r[AW-1] && (uv_sum <= {det_r[AW-1], det_r})
           && !tn_r[AW-1] && (tn_r != '0);
    sat_hit = (step_r <= rem_r);
    take    = (sat_r || (quo_r > cfg.min_dist) || ((quo_r == cfg.min_dist) && (rem_r != '0)))
           && (!best_valid_r || (quo_r < best_dist_r));
    out_free = !out_valid_r || !out_stall;
    finish   = !head.last || out_free;
    // Position: origin plus the floored offset, clamped to the signed 32-bit range.
    pos_k   = (uop.dst == rtnh_pkg::DST_POS_X) ? 2'd0 :
              (uop.dst == rtnh_pkg::DST_POS_Y) ? 2'd1 : 2'd2;
    pos_sum = {{(rtnh_pkg::POS_W-rtnh_pkg::COORD_W){cfg.origin[pos_k][rtnh_pkg::COORD_W-1]}},
               cfg.origin[pos_k]} + acc_nxt[16 +: rtnh_pkg::POS_W];
    if (!pos_sum[rtnh_pkg::POS_W-1] && (pos_sum[rtnh_pkg::POS_W-2:rtnh_pkg::COORD_W-1] != '0)) begin
      pos_sat = {1'b0, {(rtnh_pkg::COORD_W-1){1'b1}}};
    end else if (pos_sum[rtnh_pkg::POS_W-1] &&
                 (pos_sum[rtnh_pkg::POS_W-2:rtnh_pkg::COORD_W-1] != '1)) begin
      pos_sat = {1'b1, {(rtnh_pkg::COORD_W-1){1'b0}}};
    end else begin
      pos_sat = pos_sum[rtnh_pkg::COORD_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtnh_pkg::ST_IDLE: if (!q_stat.empty) state_nxt = rtnh_pkg::ST_LOAD;
      rtnh_pkg::ST_LOAD: state_nxt = rtnh_pkg::ST_MAC;
      rtnh_pkg::ST_MAC: begin
        if (mac_end) begin
          if (uop_r == rtnh_pkg::UOP_GEO_END) begin
            state_nxt = rtnh_pkg::ST_NORM;
          end else if (uop_r == rtnh_pkg::UOP_END) begin
            state_nxt = rtnh_pkg::ST_DONE;
          end else begin
            state_nxt = rtnh_pkg::ST_LOAD;
          end
        end
      end
      rtnh_pkg::ST_NORM: state_nxt = rtnh_pkg::ST_TEST;
      rtnh_pkg::ST_TEST: state_nxt = geom_ok ? rtnh_pkg::ST_SAT : rtnh_pkg::ST_DONE;
      rtnh_pkg::ST_SAT:  state_nxt = sat_hit ? rtnh_pkg::ST_QUAL : rtnh_pkg::ST_DIV;
      rtnh_pkg::ST_DIV:  if (div_end) state_nxt = rtnh_pkg::ST_QUAL;
      rtnh_pkg::ST_QUAL: state_nxt = take ? rtnh_pkg::ST_LOAD : rtnh_pkg::ST_DONE;
      rtnh_pkg::ST_DONE: if (finish) state_nxt = rtnh_pkg::ST_IDLE;
      default:           state_nxt = rtnh_pkg::ST_IDLE;
    endcase
  end

  // Controls
  always_comb begin
    do_load = 1'b0;
    do_mac  = 1'b0;
    do_norm = 1'b0;
    do_test = 1'b0;
    do_sat  = 1'b0;
    do_div  = 1'b0;
    do_qual = 1'b0;
    do_done = 1'b0;
    unique case (state_r)
      rtnh_pkg::ST_IDLE: ;
      rtnh_pkg::ST_LOAD: do_load = 1'b1;
      rtnh_pkg::ST_MAC:  do_mac  = 1'b1;
      rtnh_pkg::ST_NORM: do_norm = 1'b1;
      rtnh_pkg::ST_TEST: do_test = 1'b1;
      rtnh_pkg::ST_SAT:  do_sat  = 1'b1;
      rtnh_pkg::ST_DIV:  do_div  = 1'b1;
      rtnh_pkg::ST_QUAL: do_qual = 1'b1;
      rtnh_pkg::ST_DONE: do_done = 1'b1;
      default: ;
    endcase
    q_pop = do_done && finish;
    emit  = q_pop && head.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtnh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    if ((state_r == rtnh_pkg::ST_IDLE) && !q_stat.empty) begin
      uop_r <= '0;
    end
    if (do_load) begin
      mx_r  <= x_op;
      my_r  <= y_op[rtnh_pkg::MUL_BITS-1:0];
      bit_r <= '0;
      if (uop.first) begin
        acc_r <= '0;
      end
    end
    if (do_mac) begin
      acc_r <= acc_nxt;
      mx_r  <= mx_r <<< 1;
      my_r  <= my_r >> 1;
      bit_r <= bit_r + 1'b1;
      if (mac_end) begin
        if ((uop_r != rtnh_pkg::UOP_GEO_END) && (uop_r != rtnh_pkg::UOP_END)) begin
          uop_r <= uop_r + 1'b1;
        end
        unique case (uop.dst)
          rtnh_pkg::DST_P_X: p_r[0] <= acc_nxt[rtnh_pkg::PQ_W-1:0];
          rtnh_pkg::DST_P_Y: p_r[1] <= acc_nxt[rtnh_pkg::PQ_W-1:0];
          rtnh_pkg::DST_P_Z: p_r[2] <= acc_nxt[rtnh_pkg::PQ_W-1:0];
          rtnh_pkg::DST_Q_X: q_r[0] <= acc_nxt[rtnh_pkg::PQ_W-1:0];
          rtnh_pkg::DST_Q_Y: q_r[1] <= acc_nxt[rtnh_pkg::PQ_W-1:0];
          rtnh_pkg::DST_Q_Z: q_r[2] <= acc_nxt[rtnh_pkg::PQ_W-1:0];
          rtnh_pkg::DST_DET: det_r <= acc_nxt;
          rtnh_pkg::DST_UN:  un_r  <= acc_nxt;
          rtnh_pkg::DST_VN:  vn_r  <= acc_nxt;
          rtnh_pkg::DST_TN:  tn_r  <= acc_nxt;
          default: ;
        endcase
      end
    end
    if (do_norm && det_r[AW-1]) begin
      det_r <= -det_r;
      un_r  <= -un_r;
      vn_r  <= -vn_r;
      tn_r  <= -tn_r;
    end
    if (do_test) begin
      rem_r  <= {{(rtnh_pkg::DIV_W-(AW-1)-16){1'b0}}, tn_r[AW-2:0], 16'b0};
      step_r <= {{(rtnh_pkg::DIV_W-(AW-1)-rtnh_pkg::DIST_W){1'b0}}, det_r[AW-2:0],
                 {rtnh_pkg::DIST_W{1'b0}}};
      sat_r  <= 1'b0;
      quo_r  <= '0;
    end
    if (do_sat) begin
      if (sat_hit) begin
        sat_r <= 1'b1;
        quo_r <= '1;
      end else begin
        step_r <= step_r >> 1;
        bit_r  <= '0;
      end
    end
    if (do_div) begin
      if (sat_hit) begin
        rem_r <= rem_r - step_r;
      end
      quo_r  <= {quo_r[rtnh_pkg::DIST_W-2:0], sat_hit};
      step_r <= step_r >> 1;
      bit_r  <= bit_r + 1'b1;
    end
    if (do_qual && take) begin
      uop_r <= rtnh_pkg::UOP_POS0;
    end
  end

  // Nearest-hit tracking and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_face_r  <= '0;
      best_dist_r  <= '0;
      best_pos_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (do_qual && take) begin
        best_valid_r <= 1'b1;
        best_face_r  <= head.face;
        best_dist_r  <= quo_r;
      end
      if (do_mac && mac_end && ((uop.dst == rtnh_pkg::DST_POS_X) ||
          (uop.dst == rtnh_pkg::DST_POS_Y) || (uop.dst == rtnh_pkg::DST_POS_Z))) begin
        best_pos_r[pos_k] <= pos_sat;
      end
      if (emit) begin
        out_valid_r  <= 1'b1;
        best_valid_r <= 1'b0;
        best_face_r  <= '0;
        best_dist_r  <= '0;
        best_pos_r   <= '0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_hit_found    <= best_valid_r;
      out_hit_face     <= best_face_r;
      out_hit_distance <= best_dist_r;
      out_hit_x        <= best_pos_r[0];
      out_hit_y        <= best_pos_r[1];
      out_hit_z        <= best_pos_r[2];
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/ray_triangle_nearest_hit_unit.sv */
// Top level of the ray/triangle nearest-hit unit: configuration registers,
// front part, triangle queue and back part. Uses rtnh_pkg and the assertion header.
`include "ray_triangle_nearest_hit_unit_assert.svh"

// The unit tests a stream of triangles against one configured ray with the
// Moller-Trumbore method in exact fixed-point arithmetic and reports the nearest
// hit once the triangle marked last_face has been processed. The time a triangle
// takes is set by the single bit-serial multiply-accumulate unit, which works
// through each of the 24 product terms of the two cross and four dot products and,
// for a new nearest hit, each of the three hit-position terms, and by the 31-step
// restoring divider that forms the distance. A two-entry queue lets the input side
// take further triangles while one is at work, and the result register lets a new
// pick start while a result waits to be taken. Ties go to the earlier triangle.
// The configuration port is always ready; registers are to be written only while
// no triangle is in flight.
module ray_triangle_nearest_hit_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [rtnh_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rtnh_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_a_x,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_a_y,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_a_z,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_b_x,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_b_y,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_b_z,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_c_x,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_c_y,
  input  logic signed [rtnh_pkg::COORD_W-1:0]     in_c_z,
  input  logic [rtnh_pkg::FACE_ID_WIDTH-1:0]      in_face_id,
  input  logic                                    in_last_face,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_hit_found,
  output logic [rtnh_pkg::FACE_ID_WIDTH-1:0]      out_hit_face,
  output logic [rtnh_pkg::DIST_W-1:0]             out_hit_distance,
  output logic signed [rtnh_pkg::COORD_W-1:0]     out_hit_x,
  output logic signed [rtnh_pkg::COORD_W-1:0]     out_hit_y,
  output logic signed [rtnh_pkg::COORD_W-1:0]     out_hit_z
);

  rtnh_pkg::rtnh_cfg_t   cfg_r;
  rtnh_pkg::rtnh_tri_t   q_wr_data, q_head;
  rtnh_pkg::rtnh_qstat_t q_stat;
  logic                  q_push, q_pop;

  assign cfg_ready = 1'b1;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin   <= '0;
      cfg_r.dir[0]   <= '0;
      cfg_r.dir[1]   <= '0;
      cfg_r.dir[2]   <= rtnh_pkg::DIR_Z_RESET;
      cfg_r.thr      <= rtnh_pkg::THR_RESET;
      cfg_r.min_dist <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtnh_pkg::REG_ORIGIN_X: cfg_r.origin[0] <= cfg_wdata[rtnh_pkg::COORD_W-1:0];
        rtnh_pkg::REG_ORIGIN_Y: cfg_r.origin[1] <= cfg_wdata[rtnh_pkg::COORD_W-1:0];
        rtnh_pkg::REG_ORIGIN_Z: cfg_r.origin[2] <= cfg_wdata[rtnh_pkg::COORD_W-1:0];
        rtnh_pkg::REG_DIR_X:    cfg_r.dir[0]    <= cfg_wdata[rtnh_pkg::COORD_W-1:0];
        rtnh_pkg::REG_DIR_Y:    cfg_r.dir[1]    <= cfg_wdata[rtnh_pkg::COORD_W-1:0];
        rtnh_pkg::REG_DIR_Z:    cfg_r.dir[2]    <= cfg_wdata[rtnh_pkg::COORD_W-1:0];
        rtnh_pkg::REG_THR:      cfg_r.thr       <= cfg_wdata[rtnh_pkg::THR_W-1:0];
        rtnh_pkg::REG_MIN_DIST: cfg_r.min_dist  <= cfg_wdata[rtnh_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  rtnh_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_a_z       (in_a_z),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_b_z       (in_b_z),
    .in_c_x       (in_c_x),
    .in_c_y       (in_c_y),
    .in_c_z       (in_c_z),
    .in_face_id   (in_face_id),
    .in_last_face (in_last_face),
    .cfg          (cfg_r),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_wr_data)
  );

  rtnh_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .head    (q_head),
    .stat    (q_stat)
  );

  rtnh_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head             (q_head),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit_found    (out_hit_found),
    .out_hit_face     (out_hit_face),
    .out_hit_distance (out_hit_distance),
    .out_hit_x        (out_hit_x),
    .out_hit_y        (out_hit_y),
    .out_hit_z        (out_hit_z)
  );

  // The back part only retires a triangle that is really queued.
  `RTNH_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty)
  // Retiring the last triangle of a pick always leaves a result waiting.
  `RTNH_ASSERT_NEXT(a_last_emits, q_pop && q_head.last, out_valid)
  // A new result appears only after the last triangle of a pick was retired.
  `RTNH_ASSERT_NOW(a_result_source, $rose(out_valid), $past(q_pop && q_head.last))

endmodule

/* verif/ray_triangle_nearest_hit_unit_tb.sv */
// Self-checking testbench for the ray/triangle nearest-hit unit.
// Depends on rtnh_pkg and the RTL top level ray_triangle_nearest_hit_unit only.
module ray_triangle_nearest_hit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtnh_pkg::*;

  // Wide enough for min_distance times the largest determinant (about 133 bits).
  typedef logic signed [159:0] wide_t;

  typedef struct {
    coord_t                   a [3];
    coord_t                   b [3];
    coord_t                   c [3];
    logic [FACE_ID_WIDTH-1:0] face;
    logic                     last;
  } tri_req_t;

  typedef struct {
    logic                     found;
    logic [FACE_ID_WIDTH-1:0] face;
    logic [DIST_W-1:0]        distance;
    coord_t                   pos [3];
  } pick_res_t;

  localparam int ONE         = 65536;
  localparam int IDLE_WAIT   = 1100;   // one triangle's worst case plus margin
  localparam int STUCK_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_a_x = '0, in_a_y = '0, in_a_z = '0;
  coord_t in_b_x = '0, in_b_y = '0, in_b_z = '0;
  coord_t in_c_x = '0, in_c_y = '0, in_c_z = '0;
  logic [FACE_ID_WIDTH-1:0] in_face_id = '0;
  logic in_last_face = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_hit_found;
  logic [FACE_ID_WIDTH-1:0] out_hit_face;
  logic [DIST_W-1:0] out_hit_distance;
  coord_t out_hit_x, out_hit_y, out_hit_z;

  ray_triangle_nearest_hit_unit dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Testbench copy of the ray registers and of the nearest-hit tracking.
  coord_t            ray_org [3];
  coord_t            ray_dir [3];
  logic [THR_W-1:0]  par_thr;
  logic [DIST_W-1:0] min_dist;
  logic              near_valid;
  logic [FACE_ID_WIDTH-1:0] near_face;
  logic [DIST_W-1:0] near_dist;
  coord_t            near_pos [3];

  tri_req_t  tri_backlog [$];
  pick_res_t pick_results [$];
  int        fail_count = 0;
  bit        calm = 1'b0;       // no idling on either side while set
  bit        in_took, out_took;
  int        gap_left = 0;
  int        stall_left = 0;
  int        stuck_cycles = 0;

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic enqueue_tri(tri_req_t t);
    tri_backlog = {tri_backlog, t};
  endtask

  function automatic wide_t cr(wide_t a1, wide_t a2, wide_t b1, wide_t b2);
    return a1 * b2 - a2 * b1;
  endfunction

  // Floor division by 65536 of direction times distance, added to the origin, saturated.
  function automatic coord_t hit_axis(coord_t org, coord_t dir, logic [DIST_W-1:0] d);
    longint s;
    s = longint'(org) + ((longint'(dir) * longint'(d)) >>> 16);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return coord_t'(s);
  endfunction

  // Moller-Trumbore test in exact integers; updates the nearest hit and,
  // on the last face of a pick, queues the expected result and clears tracking.
  task automatic track_nearest(tri_req_t t);
    wide_t d [3], e1 [3], e2 [3], tv [3], p [3], q [3];
    wide_t det, un, vn, tn, num;
    logic [DIST_W-1:0] hit_dist;
    pick_res_t r;
    bit hit;
    for (int i = 0; i < 3; i++) begin
      d[i]  = ray_dir[i];
      e1[i] = wide_t'(t.b[i]) - wide_t'(t.a[i]);
      e2[i] = wide_t'(t.c[i]) - wide_t'(t.a[i]);
      tv[i] = wide_t'(ray_org[i]) - wide_t'(t.a[i]);
    end
    p[0] = cr(d[1], d[2], e2[1], e2[2]);
    p[1] = cr(d[2], d[0], e2[2], e2[0]);
    p[2] = cr(d[0], d[1], e2[0], e2[1]);
    q[0] = cr(tv[1], tv[2], e1[1], e1[2]);
    q[1] = cr(tv[2], tv[0], e1[2], e1[0]);
    q[2] = cr(tv[0], tv[1], e1[0], e1[1]);
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    un  = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
    vn  = d[0]*q[0]  + d[1]*q[1]  + d[2]*q[2];
    tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    // A zero determinant is parallel even when the threshold is zero.
    hit = det != 0 && det >= wide_t'(par_thr) && un >= 0 && un <= det && vn >= 0
          && un + vn <= det && (tn <<< 16) > wide_t'(min_dist) * det;
    if (hit) begin
      num = tn <<< 16;
      if (num >= (det <<< 31)) hit_dist = '1;
      else hit_dist = DIST_W'(num / det);
      // Strictly nearer only: the earlier of equal distances is kept.
      if (!near_valid || hit_dist < near_dist) begin
        near_valid = 1'b1;
        near_face  = t.face;
        near_dist  = hit_dist;
        for (int i = 0; i < 3; i++) near_pos[i] = hit_axis(ray_org[i], ray_dir[i], hit_dist);
      end
    end
    if (t.last) begin
      r.found    = near_valid;
      r.face     = near_face;
      r.distance = near_dist;
      r.pos      = near_pos;
      pick_results = {pick_results, r};
      near_valid = 1'b0;
      near_face  = '0;
      near_dist  = '0;
      near_pos   = '{default: '0};
    end
  endtask

  // Input side: requests are accepted at the rising edge, the next one is
  // presented at the falling edge after a gap drawn at random outside calm phases.
  always @(posedge clk) begin
    in_took = in_valid && !in_stall;
    if (in_took) begin
      tri_req_t t;
      t.a = '{in_a_x, in_a_y, in_a_z};
      t.b = '{in_b_x, in_b_y, in_b_z};
      t.c = '{in_c_x, in_c_y, in_c_z};
      t.face = in_face_id;
      t.last = in_last_face;
      track_nearest(t);
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (gap_left > 0 || tri_backlog.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        tri_req_t t;
        t = tri_backlog.pop_front();
        {in_a_x, in_a_y, in_a_z} <= {t.a[0], t.a[1], t.a[2]};
        {in_b_x, in_b_y, in_b_z} <= {t.b[0], t.b[1], t.b[2]};
        {in_c_x, in_c_y, in_c_z} <= {t.c[0], t.c[1], t.c[2]};
        in_face_id   <= t.face;
        in_last_face <= t.last;
        in_valid     <= 1'b1;
        gap_left = calm ? 0 : $urandom_range(0, 14);
      end
    end
  end

  // Result side: compare each accepted result with the oldest expected pick.
  always @(posedge clk) begin
    out_took = out_valid && !out_stall;
    if (out_took) begin
      if (pick_results.size() == 0) begin
        report("unexpected result", out_hit_face, 0);
      end else begin
        pick_res_t w;
        w = pick_results.pop_front();
        if (out_hit_found !== w.found) report("hit_found", out_hit_found, w.found);
        if (out_hit_face !== w.face) report("hit_face", out_hit_face, w.face);
        if (out_hit_distance !== w.distance)
          report("hit_distance", out_hit_distance, w.distance);
        if (out_hit_x !== w.pos[0]) report("hit_x", out_hit_x, w.pos[0]);
        if (out_hit_y !== w.pos[1]) report("hit_y", out_hit_y, w.pos[1]);
        if (out_hit_z !== w.pos[2]) report("hit_z", out_hit_z, w.pos[2]);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) stall_left = calm ? 0 : $urandom_range(0, 14);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog: too long without any request, result or register write moving.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X: ray_org[0] = coord_t'(val);
      REG_ORIGIN_Y: ray_org[1] = coord_t'(val);
      REG_ORIGIN_Z: ray_org[2] = coord_t'(val);
      REG_DIR_X:    ray_dir[0] = coord_t'(val);
      REG_DIR_Y:    ray_dir[1] = coord_t'(val);
      REG_DIR_Z:    ray_dir[2] = coord_t'(val);
      REG_THR:      par_thr    = val[THR_W-1:0];
      REG_MIN_DIST: min_dist   = val[DIST_W-1:0];
      default: ;    // indexes past the list are ignored by the block
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ray(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy,
                         coord_t dz, logic [THR_W-1:0] thr, logic [DIST_W-1:0] md);
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_ORIGIN_Z, CFG_DATA_W'(oz));
    write_reg(REG_DIR_X, CFG_DATA_W'(dx));
    write_reg(REG_DIR_Y, CFG_DATA_W'(dy));
    write_reg(REG_DIR_Z, CFG_DATA_W'(dz));
    write_reg(REG_THR, CFG_DATA_W'(thr));
    write_reg(REG_MIN_DIST, CFG_DATA_W'(md));
  endtask

  // Sender holds back until every expected pick result has been taken,
  // then the block is given time to finish any triangle without a result.
  task automatic wait_idle();
    do @(posedge clk); while (tri_backlog.size() != 0 || in_valid || pick_results.size() != 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  function automatic tri_req_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz, int face, bit last);
    tri_req_t t;
    t.a = '{ax, ay, az};
    t.b = '{bx, by, bz};
    t.c = '{cx, cy, cz};
    t.face = face;
    t.last = last;
    return t;
  endfunction

  // Triangle centred on the ray at parameter ray_param (Q16.16), so most of these hit.
  function automatic tri_req_t mk_on_ray(longint ray_param, int spread, int face, bit last);
    tri_req_t t;
    longint pt, o1, o2;
    for (int i = 0; i < 3; i++) begin
      pt = longint'(ray_org[i]) + ((longint'(ray_dir[i]) * ray_param) >>> 16);
      o1 = $signed($urandom_range(0, 2 * spread)) - spread;
      o2 = $signed($urandom_range(0, 2 * spread)) - spread;
      t.a[i] = coord_t'(pt + o1);
      t.b[i] = coord_t'(pt + o2);
      t.c[i] = coord_t'(pt - o1 - o2);
    end
    t.face = face;
    t.last = last;
    return t;
  endfunction

  function automatic tri_req_t mk_noise(int face, bit last);
    tri_req_t t;
    for (int i = 0; i < 3; i++) begin
      t.a[i] = $urandom;
      t.b[i] = $urandom;
      t.c[i] = $urandom;
    end
    t.face = face;
    t.last = last;
    return t;
  endfunction

  // Random picks of one to six faces, mostly triangles lying across the ray.
  task automatic random_picks(int n_items);
    tri_req_t prev, t;
    int n, k, pick_len;
    n = 0;
    prev = mk_noise(0, 1'b0);
    while (n < n_items) begin
      pick_len = $urandom_range(1, 6);
      for (int j = 0; j < pick_len; j++) begin
        k = $urandom_range(0, 9);
        if (k < 6)
          t = mk_on_ray($urandom_range(ONE / 8, 60 * ONE), 1 << $urandom_range(8, 22),
                        $urandom, 1'b0);
        else if (k == 6) t = prev;                         // same distance again
        else if (k == 7) t = mk_on_ray(-longint'($urandom_range(1, 40 * ONE)), 1 << 20,
                                       $urandom, 1'b0);    // behind the origin
        else if (k == 8) begin
          t = mk_noise($urandom, 1'b0);
          t.b = t.a;                                       // degenerate, zero determinant
        end else t = mk_noise($urandom, 1'b0);
        t.face = $urandom;
        t.last = (j == pick_len - 1);
        enqueue_tri(t);
        prev = t;
        n++;
      end
    end
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, DIR_Z_RESET};
    par_thr = THR_RESET;
    min_dist = '0;
    near_valid = 1'b0;
    near_face = '0;
    near_dist = '0;
    near_pos = '{default: '0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed picks with the reset ray: along +z from the origin.
    calm = 1'b1;
    enqueue_tri(mk_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 1, 1));
    enqueue_tri(mk_tri(-ONE, -ONE, 5*ONE, -ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 2, 1));
    enqueue_tri(mk_tri(-ONE, -ONE, -5*ONE, ONE, -ONE, -5*ONE, 0, ONE, -5*ONE, 3, 1));
    // Two equal distances: the first face must be kept.
    enqueue_tri(mk_tri(-ONE, -ONE, 4*ONE, ONE, -ONE, 4*ONE, 0, ONE, 4*ONE, 4, 0));
    enqueue_tri(mk_tri(-ONE, -ONE, 4*ONE, ONE, -ONE, 4*ONE, 0, ONE, 4*ONE, 5, 1));
    // A farther hit followed by a nearer one.
    enqueue_tri(mk_tri(-ONE, -ONE, 8*ONE, ONE, -ONE, 8*ONE, 0, ONE, 8*ONE, 6, 0));
    enqueue_tri(mk_tri(-ONE, -ONE, 3*ONE, ONE, -ONE, 3*ONE, 0, ONE, 3*ONE, 7, 1));
    // Ray through a vertex and through an edge: u = v = 0, then v = 0 alone.
    enqueue_tri(mk_tri(0, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE, 8, 1));
    enqueue_tri(mk_tri(-ONE, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE, 9, 1));
    // Extreme field values.
    enqueue_tri(mk_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                       32'h80000000, 16'hffff, 1));
    enqueue_tri(mk_tri(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h7fffffff, 0, 32'h7fffffff,
                       32'h7fffffff, 16'hffff, 1));
    enqueue_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    // Very distant hit: the distance lies just below the saturation limit.
    enqueue_tri(mk_tri(-ONE, -ONE, 32'h7fff0000, ONE, -ONE, 32'h7fff0000,
                       0, ONE, 32'h7fff0000, 10, 1));
    wait_idle();

    // Zero threshold, a rejected-looking distance floor and an ignored index.
    write_reg(REG_UNUSED, '1);
    set_ray(0, 0, 0, 0, 0, 1, 0, 3*ONE);
    enqueue_tri(mk_tri(-ONE, -ONE, 3*ONE, ONE, -ONE, 3*ONE, 0, ONE, 3*ONE, 11, 1));
    enqueue_tri(mk_tri(-ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, 0, ONE, 2*ONE, 12, 0));
    enqueue_tri(mk_tri(-ONE, -ONE, 7*ONE, ONE, -ONE, 7*ONE, 0, ONE, 7*ONE, 13, 1));
    enqueue_tri(mk_tri(5, 5, ONE, 5, 5, ONE, 0, ONE, 4*ONE, 14, 1));
    wait_idle();

    // Origin at the corners of the range so that positions saturate.
    set_ray(32'h7fff0000, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, ONE, 0, 0);
    enqueue_tri(mk_tri(32'h7fff0000, 32'h80000000, 8*ONE, 32'h7fff0000, 32'h80000000,
                       8*ONE, 32'h7fff0000, 32'h80000000, 8*ONE, 15, 1));
    enqueue_tri(mk_tri(-ONE, -ONE, 10*ONE, 32'h7fffffff, 32'h7fffffff, 10*ONE,
                       32'h80000000, 32'h7fffffff, 10*ONE, 16, 1));
    wait_idle();

    // Random phases over a spread of rays; every third phase has calm handshakes, the rest busy ones.
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph % 3 == 0);
      case (ph)
        0: set_ray(0, 0, 0, 0, 0, ONE, THR_RESET, 0);
        1: set_ray($signed($urandom) >>> 8, $signed($urandom) >>> 8, $signed($urandom) >>> 8,
                   $signed($urandom) >>> 14, $signed($urandom) >>> 14,
                   $signed($urandom) >>> 14, $urandom_range(0, 1 << 20),
                   $urandom_range(0, 4 * ONE));
        2: set_ray(32'h80000000, 32'h7fffffff, $urandom, ONE, -ONE, 2 * ONE, 0, 0);
        3: set_ray(0, 0, 0, 3 * ONE, -2 * ONE, ONE, 40'hffffffffff, 31'h7fffffff);
        4: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   {$urandom, 8'($urandom)}, $urandom);
        default: set_ray(ONE, 2 * ONE, -3 * ONE, -ONE, ONE / 2, ONE, 1, 1);
      endcase
      random_picks(100);
      wait_idle();
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
